// ===== src/cbco_pkg.sv =====
// shared widths, register indexes and interface structs for the colour blob centroid block
// no dependencies; used by cbco_pixel, cbco_div and color_blob_centroid_offset
package cbco_pkg;

	localparam int CountW = 23;
	localparam int SumW   = 34;
	localparam int ThrW   = 31;
	localparam int OffW   = 12;
	localparam int HsvW   = 24;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 31;

	localparam int OFF_MIN = -1024;
	localparam int OFF_MAX = 2047;

	localparam logic [CfgIdxW-1:0] REG_LOWER_HSV      = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_UPPER_HSV      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_AREA_THRESHOLD = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ROI_LEFT       = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ROI_TOP        = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ROI_WIDTH      = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_ROI_HEIGHT     = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH    = 3'd7;

	// colour window and region of interest seen by the pixel stage
	typedef struct packed {
		logic [HsvW-1:0] lower_hsv;
		logic [HsvW-1:0] upper_hsv;
		logic [10:0]     roi_left;
		logic [10:0]     roi_top;
		logic [11:0]     roi_width;
		logic [11:0]     roi_height;
	} win_cfg_t;

	// accumulator values including the current pixel
	typedef struct packed {
		logic [CountW-1:0] count;
		logic [SumW-1:0]   sum;
	} acc_t;

	// divider status and results
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [SumW-1:0]   quotient;
		logic [CountW-1:0] remainder;
	} div_res_t;

endpackage

// ===== src/cbco_pixel.sv =====
// pixel stage: colour window test, roi test, raster position and frame accumulators
// depends on cbco_pkg
module cbco_pixel #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	localparam int WidthW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            hue,
	input  logic [7:0]            saturation,
	input  logic [7:0]            brightness,
	input  logic                  frame_end,
	input  cbco_pkg::win_cfg_t    cfg,
	input  logic [WidthW-1:0]     eff_width,
	output cbco_pkg::acc_t        acc
);

	localparam int ColW    = $clog2(MAX_WIDTH);
	localparam int RowW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int ColCmpW = (ColW > 12) ? ColW : 12;
	localparam int RowCmpW = (RowW > 12) ? RowW : 12;

	logic [ColW-1:0]                 column_q;
	logic [RowW-1:0]                 row_q;
	logic [cbco_pkg::CountW-1:0]     count_q;
	logic [cbco_pkg::SumW-1:0]       sum_q;

	logic [ColCmpW-1:0] col_e, col_left, col_rel;
	logic [RowCmpW-1:0] row_e, row_top, row_rel;
	logic               in_col, in_row, colour_ok, hit, col_wrap;

	always_comb begin
		col_e    = ColCmpW'(column_q);
		col_left = ColCmpW'(cfg.roi_left);
		col_rel  = col_e - col_left;
		in_col   = (col_e >= col_left) && (col_rel < ColCmpW'(cfg.roi_width));

		row_e   = RowCmpW'(row_q);
		row_top = RowCmpW'(cfg.roi_top);
		row_rel = row_e - row_top;
		in_row  = (row_e >= row_top) && (row_rel < RowCmpW'(cfg.roi_height));

		colour_ok = (hue >= cfg.lower_hsv[7:0]) && (hue <= cfg.upper_hsv[7:0]) &&
			(saturation >= cfg.lower_hsv[15:8]) && (saturation <= cfg.upper_hsv[15:8]) &&
			(brightness >= cfg.lower_hsv[23:16]) && (brightness <= cfg.upper_hsv[23:16]);

		hit = in_col && in_row && colour_ok;

		acc.count = hit ? (count_q + cbco_pkg::CountW'(1)) : count_q;
		acc.sum   = hit ? (sum_q + cbco_pkg::SumW'(col_rel)) : sum_q;

		// column wraps once the next position reaches the row length
		col_wrap = (WidthW'(column_q) + WidthW'(1)) >= eff_width;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			count_q  <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			if (frame_end) begin
				column_q <= '0;
				row_q    <= '0;
				count_q  <= '0;
				sum_q    <= '0;
			end else begin
				count_q <= acc.count;
				sum_q   <= acc.sum;
				if (col_wrap) begin
					column_q <= '0;
					if (row_q == RowW'(MAX_HEIGHT - 1)) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + RowW'(1);
					end
				end else begin
					column_q <= column_q + ColW'(1);
				end
			end
		end
	end

endmodule

// ===== src/cbco_div.sv =====
// restoring divider, one quotient bit per cycle: column sum over match count
// depends on cbco_pkg
module cbco_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cbco_pkg::SumW-1:0]      dividend,
	input  logic [cbco_pkg::CountW-1:0]    divisor,
	output cbco_pkg::div_res_t             res
);

	localparam int SumW   = cbco_pkg::SumW;
	localparam int CountW = cbco_pkg::CountW;
	localparam int StepW  = $clog2(SumW + 1);

	logic [SumW-1:0]   quo_q;
	logic [CountW-1:0] rem_q;
	logic [CountW-1:0] dvs_q;
	logic [StepW-1:0]  step_q;
	logic              busy_q, done_q;

	logic [CountW:0]   shifted;
	logic [CountW+1:0] trial;
	logic              take;

	always_comb begin
		shifted = {rem_q, quo_q[SumW-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		take    = !trial[CountW+1];

		res.busy      = busy_q;
		res.done      = done_q;
		res.quotient  = quo_q;
		res.remainder = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + StepW'(1);
			if (step_q == StepW'(SumW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? trial[CountW-1:0] : shifted[CountW-1:0];
			quo_q <= {quo_q[SumW-2:0], take};
		end
	end

endmodule

// ===== src/color_blob_centroid_offset.sv =====
// top level of the colour blob centroid block: config registers, frame-end sequencer, output
// depends on cbco_pkg, cbco_pixel and cbco_div
//
// Takes a raster stream of HSV pixels and, at the pixel marked frame_end, returns one item:
// found is set when 255 times the number of matching pixels exceeds area_threshold, and
// offset is then the mean roi-relative column of the matching pixels minus half the frame
// width, truncated toward zero and saturated to -1024..2047 (zero when not found). A pixel
// matches when hue, saturation and brightness lie within the inclusive bounds of lower_hsv
// and upper_hsv and its raster position lies inside the region of interest. Ordinary pixels
// are taken one per cycle outside a division, also while a result waits on out_stall.
// A frame-end pixel that finds a blob starts a restoring divider that yields one quotient
// bit per cycle; the input stalls through its 34 divide steps, a wait for the divider to
// report done and the forming of the result, which waits for the output slot. A frame end
// without a blob puts its result straight into the output slot. A frame-end pixel is also
// held off while the previous result is still stalled. Configuration is written through
// cfg_valid/cfg_ready, cfg_ready is always high, and writes belong between frames or between pixels.
module color_blob_centroid_offset #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel input
	input  logic [7:0]                         hue,
	input  logic [7:0]                         saturation,
	input  logic [7:0]                         brightness,
	input  logic                               frame_end,
	input  logic                               in_valid,
	output logic                               in_stall,
	// result output
	output logic signed [cbco_pkg::OffW-1:0]   offset,
	output logic                               found,
	output logic                               out_valid,
	input  logic                               out_stall,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cbco_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [cbco_pkg::CfgDataW-1:0]      cfg_data
);

	localparam int WidthW  = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
	localparam int SumW    = cbco_pkg::SumW;
	localparam int CountW  = cbco_pkg::CountW;
	localparam int ThrW    = cbco_pkg::ThrW;
	localparam int OffW    = cbco_pkg::OffW;
	localparam int OffCalcW = SumW + 2;

	localparam logic signed [OffCalcW-1:0] OffLo = OffCalcW'(cbco_pkg::OFF_MIN);
	localparam logic signed [OffCalcW-1:0] OffHi = OffCalcW'(cbco_pkg::OFF_MAX);

	typedef enum logic [1:0] {
		ST_PIX,
		ST_DIV,
		ST_RES
	} state_t;

	// configuration registers
	logic [cbco_pkg::HsvW-1:0] lower_hsv_q, upper_hsv_q;
	logic [ThrW-1:0]           area_threshold_q;
	logic [10:0]               roi_left_q, roi_top_q;
	logic [11:0]               roi_width_q, roi_height_q, frame_width_q;

	state_t                    state_q;
	logic                      out_valid_q, found_q;
	logic [OffW-1:0]           offset_q;

	cbco_pkg::win_cfg_t        win_cfg;
	cbco_pkg::acc_t            acc;
	cbco_pkg::div_res_t        div_res;

	logic [WidthW-1:0]         fw_e, eff_width, half_width;
	logic                      in_accept, out_pop, slot_free;
	logic [ThrW-1:0]           area_scaled;
	logic                      blob_found, div_start;
	logic [SumW-1:0]           q_adj;
	logic signed [OffCalcW-1:0] off_w;
	logic [OffW-1:0]           off_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_hsv_q      <= '0;
			upper_hsv_q      <= '1;
			area_threshold_q <= '0;
			roi_left_q       <= '0;
			roi_top_q        <= '0;
			roi_width_q      <= 12'd2048;
			roi_height_q     <= 12'd2048;
			frame_width_q    <= 12'd640;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbco_pkg::REG_LOWER_HSV:      lower_hsv_q      <= cfg_data[23:0];
				cbco_pkg::REG_UPPER_HSV:      upper_hsv_q      <= cfg_data[23:0];
				cbco_pkg::REG_AREA_THRESHOLD: area_threshold_q <= cfg_data[30:0];
				cbco_pkg::REG_ROI_LEFT:       roi_left_q       <= cfg_data[10:0];
				cbco_pkg::REG_ROI_TOP:        roi_top_q        <= cfg_data[10:0];
				cbco_pkg::REG_ROI_WIDTH:      roi_width_q      <= cfg_data[11:0];
				cbco_pkg::REG_ROI_HEIGHT:     roi_height_q     <= cfg_data[11:0];
				cbco_pkg::REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		win_cfg.lower_hsv  = lower_hsv_q;
		win_cfg.upper_hsv  = upper_hsv_q;
		win_cfg.roi_left   = roi_left_q;
		win_cfg.roi_top    = roi_top_q;
		win_cfg.roi_width  = roi_width_q;
		win_cfg.roi_height = roi_height_q;

		// row length: zero counts as one, anything past MAX_WIDTH is clipped to it
		fw_e = WidthW'(frame_width_q);
		if (fw_e == '0) begin
			eff_width = WidthW'(1);
		end else if (fw_e > WidthW'(MAX_WIDTH)) begin
			eff_width = WidthW'(MAX_WIDTH);
		end else begin
			eff_width = fw_e;
		end
		half_width = eff_width >> 1;
	end

	// output slot can take a new item this cycle
	assign out_pop   = out_valid_q && !out_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// a frame-end pixel needs the output slot; outside ST_PIX every pixel waits, else ordinary pixels flow on
	assign in_stall  = (state_q != ST_PIX) || (frame_end && !slot_free);
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		// 255 * count as (count << 8) - count, fits 31 bits
		area_scaled = {acc.count, 8'd0} - ThrW'(acc.count);
		blob_found  = area_scaled > area_threshold_q;
		div_start   = in_accept && frame_end && blob_found && (acc.count != '0);
	end

	cbco_pixel #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pixel (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.frame_end  (frame_end),
		.cfg        (win_cfg),
		.eff_width  (eff_width),
		.acc        (acc)
	);

	cbco_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc.sum),
		.divisor  (acc.count),
		.res      (div_res)
	);

	// truncation toward zero of (sum - half*count) / count, built from floor(sum / count):
	// below the half width the quotient rounds up whenever the division left a remainder
	always_comb begin
		if ((div_res.quotient < SumW'(half_width)) && (div_res.remainder != '0)) begin
			q_adj = div_res.quotient + SumW'(1);
		end else begin
			q_adj = div_res.quotient;
		end
		off_w = $signed({2'b00, q_adj}) - $signed(OffCalcW'(half_width));
		if (off_w < OffLo) begin
			off_sat = OffLo[OffW-1:0];
		end else if (off_w > OffHi) begin
			off_sat = OffHi[OffW-1:0];
		end else begin
			off_sat = off_w[OffW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PIX;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			offset_q    <= '0;
		end else begin
			unique case (state_q)
				ST_PIX: begin
					if (div_start) begin
						if (out_pop) begin
							out_valid_q <= 1'b0;
						end
						state_q <= ST_DIV;
					end else if (in_accept && frame_end) begin
						// no blob: result goes out straight away with a zero offset
						out_valid_q <= 1'b1;
						found_q     <= blob_found;
						offset_q    <= '0;
					end else if (out_pop) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (out_pop) begin
						out_valid_q <= 1'b0;
					end
					if (div_res.done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b1;
						offset_q    <= off_sat;
						state_q     <= ST_PIX;
					end
				end
				default: begin
					state_q <= ST_PIX;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign offset    = $signed(offset_q);

endmodule

// ===== tb/color_blob_centroid_offset_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for color_blob_centroid_offset: directed table then random frames
// depends on cbco_pkg and the color_blob_centroid_offset rtl; no files, no arguments
module color_blob_centroid_offset_tb;

	localparam int CfgIdxW   = cbco_pkg::CfgIdxW;
	localparam int CfgDataW  = cbco_pkg::CfgDataW;
	localparam int OffW      = cbco_pkg::OffW;
	localparam int FrameMaxW = 2048;
	localparam int RowMax    = 2048;
	// covers the input stall of one frame end with a blob, plus margin
	localparam int DrainCycles = 40;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	// one line of the directed stimulus table
	typedef struct packed {
		row_kind_t              kind;
		logic [CfgIdxW-1:0]     idx;
		logic [CfgDataW-1:0]    data;
		logic [7:0]             h;
		logic [7:0]             s;
		logic [7:0]             b;
		logic                   fe;
		logic                   typed;
		logic signed [OffW-1:0] off;
		logic                   fnd;
	} plan_row_t;

	// one centroid item as the block returns it
	typedef struct packed {
		logic signed [OffW-1:0] off;
		logic                   fnd;
	} centroid_t;

	logic clk = 1'b0;
	logic arst_n;
	logic [7:0] hue, saturation, brightness;
	logic frame_end, in_valid, in_stall;
	logic signed [OffW-1:0] offset;
	logic found, out_valid, out_stall;
	logic cfg_valid, cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int err_cnt = 0;

	// centroids still owed by the block, oldest first
	centroid_t expected_centroids[$];
	plan_row_t plan[$];

	// register copies of the predictor
	logic [23:0] lo_hsv, hi_hsv;
	logic [30:0] area_thr;
	logic [10:0] roi_l, roi_t;
	logic [11:0] roi_w, roi_h, frm_w;
	// raster position and accumulators of the predictor
	logic [10:0] pos_col, pos_row;
	logic [22:0] match_cnt;
	logic [33:0] col_sum;

	color_blob_centroid_offset #(
		.MAX_WIDTH(FrameMaxW),
		.MAX_HEIGHT(RowMax)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.frame_end(frame_end),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.offset(offset),
		.found(found),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	// results are sampled at the falling edge, when all inputs and outputs are settled,
	// and checked right after the rising edge that moves them
	always begin : result_watch
		logic take;
		centroid_t got, want;
		@(negedge clk);
		take = (out_valid === 1'b1) && (out_stall === 1'b0);
		got.off = offset;
		got.fnd = found;
		@(posedge clk);
		if (take) begin
			if (expected_centroids.size() == 0) begin
				$display("%0t unexpected centroid item: offset %0d found %0b",
					$time, got.off, got.fnd);
				err_cnt++;
			end else begin
				want = expected_centroids.pop_front();
				if (want.off !== got.off) begin
					$display("%0t offset mismatch: expected %0d, actual %0d",
						$time, want.off, got.off);
					err_cnt++;
				end
				if (want.fnd !== got.fnd) begin
					$display("%0t found mismatch: expected %0b, actual %0b",
						$time, want.fnd, got.fnd);
					err_cnt++;
				end
			end
		end
	end

	function automatic plan_row_t write_row(input logic [CfgIdxW-1:0] idx, input int data);
		plan_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = CfgDataW'(data);
		return r;
	endfunction

	function automatic plan_row_t pixel_row(input logic [7:0] h, s, b, input logic fe);
		plan_row_t r;
		r = '0;
		r.kind = ROW_PIXEL;
		r.h = h;
		r.s = s;
		r.b = b;
		r.fe = fe;
		return r;
	endfunction

	// frame-end pixel whose centroid is written out by hand
	function automatic plan_row_t known_row(input logic [7:0] h, s, b,
			input int off, input logic fnd);
		plan_row_t r;
		r = pixel_row(h, s, b, 1'b1);
		r.typed = 1'b1;
		r.off = OffW'(off);
		r.fnd = fnd;
		return r;
	endfunction

	task automatic reset_model();
		lo_hsv = 24'h000000;
		hi_hsv = 24'hFFFFFF;
		area_thr = '0;
		roi_l = '0;
		roi_t = '0;
		roi_w = 12'd2048;
		roi_h = 12'd2048;
		frm_w = 12'd640;
		pos_col = '0;
		pos_row = '0;
		match_cnt = '0;
		col_sum = '0;
	endtask

	task automatic apply_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		case (idx)
			cbco_pkg::REG_LOWER_HSV: lo_hsv = data[23:0];
			cbco_pkg::REG_UPPER_HSV: hi_hsv = data[23:0];
			cbco_pkg::REG_AREA_THRESHOLD: area_thr = data[30:0];
			cbco_pkg::REG_ROI_LEFT: roi_l = data[10:0];
			cbco_pkg::REG_ROI_TOP: roi_t = data[10:0];
			cbco_pkg::REG_ROI_WIDTH: roi_w = data[11:0];
			cbco_pkg::REG_ROI_HEIGHT: roi_h = data[11:0];
			cbco_pkg::REG_FRAME_WIDTH: frm_w = data[11:0];
			default: ;
		endcase
	endtask

	// width the raster really wraps at: zero counts as one, clamped to the maximum
	function automatic int line_width();
		if (frm_w == 0)
			return 1;
		if (frm_w > FrameMaxW)
			return FrameMaxW;
		return int'(frm_w);
	endfunction

	// predicts one accepted pixel; a frame end queues its centroid, the typed one if given
	task automatic track_pixel(input logic [7:0] h, s, b, input logic fe,
			input logic typed, input centroid_t typed_res);
		int w, c, r, lft, top, nc, nr;
		logic hit;
		longint diff, q;
		centroid_t res;
		w = line_width();
		c = int'(pos_col);
		r = int'(pos_row);
		lft = int'(roi_l);
		top = int'(roi_t);
		hit = (c >= lft) && ((c - lft) < int'(roi_w)) && (r >= top) && ((r - top) < int'(roi_h))
			&& (h >= lo_hsv[7:0]) && (h <= hi_hsv[7:0])
			&& (s >= lo_hsv[15:8]) && (s <= hi_hsv[15:8])
			&& (b >= lo_hsv[23:16]) && (b <= hi_hsv[23:16]);
		if (hit) begin
			match_cnt = match_cnt + 23'd1;
			col_sum = col_sum + 34'(c - lft);
		end
		if (!fe) begin
			nc = c + 1;
			if (nc >= w) begin
				pos_col = '0;
				nr = r + 1;
				// row wraps without a frame end
				pos_row = (nr >= RowMax) ? 11'd0 : 11'(nr);
			end else begin
				pos_col = 11'(nc);
			end
		end else begin
			res.fnd = (255 * longint'(match_cnt)) > longint'(area_thr);
			res.off = '0;
			if (res.fnd) begin
				diff = longint'(col_sum) - longint'(w / 2) * longint'(match_cnt);
				q = diff / longint'(match_cnt);
				if (q < cbco_pkg::OFF_MIN)
					q = longint'(cbco_pkg::OFF_MIN);
				if (q > cbco_pkg::OFF_MAX)
					q = longint'(cbco_pkg::OFF_MAX);
				res.off = q[OffW-1:0];
			end
			expected_centroids.push_back(typed ? typed_res : res);
			pos_col = '0;
			pos_row = '0;
			match_cnt = '0;
			col_sum = '0;
		end
	endtask

	// offers one pixel after random idle cycles; returns at the accepting edge
	task automatic send_pixel(input logic [7:0] h, s, b, input logic fe,
			input logic typed, input centroid_t typed_res);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		hue <= h;
		saturation <= s;
		brightness <= b;
		frame_end <= fe;
		in_valid <= 1'b1;
		@(negedge clk);
		while (in_stall !== 1'b0)
			@(negedge clk);
		track_pixel(h, s, b, fe, typed, typed_res);
		@(posedge clk);
	endtask

	// leaves cfg_valid high so that writes can follow back to back
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (cfg_ready !== 1'b1)
			@(negedge clk);
		apply_write(idx, data);
		@(posedge clk);
	endtask

	// stop offering pixels, wait for every owed centroid, then let the divider go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_centroids.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// channel value: mostly near the colour window, sometimes anywhere
	function automatic logic [7:0] pick_chan(input logic [7:0] lo, hi);
		int a, z;
		if (lo > hi || $urandom_range(3) == 0)
			return 8'($urandom_range(255));
		a = (lo < 2) ? 0 : lo - 2;
		z = (hi > 253) ? 255 : hi + 2;
		return 8'($urandom_range(z, a));
	endfunction

	// draws and writes a full register set; cfg_valid is left high
	task automatic choose_setting();
		logic [23:0] lo, hi;
		logic [7:0] a, z, t;
		logic [6:0] junk;
		int k, fw, eff, lft, rw, top, rh;
		longint thr;
		for (k = 0; k < 3; k++) begin
			a = 8'($urandom_range(255));
			z = 8'($urandom_range(255));
			case ($urandom_range(3))
				0: begin
					a = 8'd0;
					z = 8'd255;
				end
				1: begin
					if (a > z) begin
						t = a;
						a = z;
						z = t;
					end
				end
				2: z = (a > 215) ? 8'd255 : a + 8'($urandom_range(40));
				default: ; // may leave an empty window
			endcase
			lo[k*8 +: 8] = a;
			hi[k*8 +: 8] = z;
		end
		case ($urandom_range(9))
			0: fw = 0;
			1: fw = FrameMaxW;
			2: fw = $urandom_range(4095, FrameMaxW + 1); // clamps to the maximum
			3: fw = $urandom_range(FrameMaxW - 1, 25);
			default: fw = $urandom_range(24, 1);
		endcase
		eff = (fw == 0) ? 1 : ((fw > FrameMaxW) ? FrameMaxW : fw);
		lft = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range((eff < 24) ? eff : 24);
		case ($urandom_range(7))
			0: rw = 0;
			1: rw = 2048;
			2: rw = $urandom_range(4095);
			default: rw = $urandom_range(8, 1);
		endcase
		top = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(3);
		case ($urandom_range(7))
			0: rh = 0;
			1: rh = 2048;
			2: rh = 4095;
			default: rh = $urandom_range(6, 1);
		endcase
		case ($urandom_range(5))
			0: thr = 0;
			1: thr = 64'h7FFFFFFF;
			2: thr = longint'($urandom >> 1);
			default: thr = longint'($urandom_range(255 * 6));
		endcase
		// bits above the colour fields are don't-care
		junk = 7'($urandom);
		write_reg(cbco_pkg::REG_LOWER_HSV, {junk, lo});
		junk = 7'($urandom);
		write_reg(cbco_pkg::REG_UPPER_HSV, {junk, hi});
		write_reg(cbco_pkg::REG_AREA_THRESHOLD, thr[30:0]);
		write_reg(cbco_pkg::REG_ROI_LEFT, CfgDataW'(lft));
		write_reg(cbco_pkg::REG_ROI_TOP, CfgDataW'(top));
		write_reg(cbco_pkg::REG_ROI_WIDTH, CfgDataW'(rw));
		write_reg(cbco_pkg::REG_ROI_HEIGHT, CfgDataW'(rh));
		write_reg(cbco_pkg::REG_FRAME_WIDTH, CfgDataW'(fw));
	endtask

	// len pixels in raster order, the last one closing the frame
	task automatic send_frame(input int len);
		int i;
		for (i = 0; i < len; i++) begin
			send_pixel(pick_chan(hi_hsv[7:0] < lo_hsv[7:0] ? 8'd0 : lo_hsv[7:0], hi_hsv[7:0]),
				pick_chan(lo_hsv[15:8], hi_hsv[15:8]),
				pick_chan(lo_hsv[23:16], hi_hsv[23:16]),
				i == len - 1, 1'b0, '0);
		end
	endtask

	// run limit, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("[color_blob_centroid_offset] ERROR");
		$finish;
	end

	initial begin : stimulus
		int ph, fr, sent, eff, len;
		centroid_t typed_res;
		arst_n <= 1'b0;
		hue <= '0;
		saturation <= '0;
		brightness <= '0;
		frame_end <= 1'b0;
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		reset_model();

		// directed table: extremes, window edges, threshold edges, width and roi corner cases
		// defaults: full window, threshold 0, width 640 -> single pixel at column 0 is -320
		plan.push_back(known_row(8'h00, 8'h00, 8'h00, -320, 1'b1));
		plan.push_back(write_row(cbco_pkg::REG_FRAME_WIDTH, 2048));
		plan.push_back(known_row(8'hFF, 8'hFF, 8'hFF, -1024, 1'b1));
		plan.push_back(write_row(cbco_pkg::REG_LOWER_HSV, 24'h808080));
		// hue one below the lower bound: nothing counted, not found
		plan.push_back(known_row(8'h7F, 8'h80, 8'h80, 0, 1'b0));
		plan.push_back(write_row(cbco_pkg::REG_UPPER_HSV, 24'h808080));
		plan.push_back(pixel_row(8'h80, 8'h80, 8'h80, 1'b0));
		plan.push_back(pixel_row(8'h80, 8'h80, 8'h81, 1'b0));
		plan.push_back(pixel_row(8'h80, 8'h80, 8'h80, 1'b1));
		// zero frame width acts as one pixel per row, half width 0
		plan.push_back(write_row(cbco_pkg::REG_FRAME_WIDTH, 0));
		plan.push_back(pixel_row(8'h80, 8'h80, 8'h80, 1'b0));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b1));
		plan.push_back(write_row(cbco_pkg::REG_AREA_THRESHOLD, 31'h7FFFFFFF));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b0));
		plan.push_back(write_row(cbco_pkg::REG_AREA_THRESHOLD, 254));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b1));
		// 255 times one is not strictly above 255
		plan.push_back(write_row(cbco_pkg::REG_AREA_THRESHOLD, 255));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b0));
		plan.push_back(write_row(cbco_pkg::REG_AREA_THRESHOLD, 0));
		// width above the maximum clamps to 2048
		plan.push_back(write_row(cbco_pkg::REG_FRAME_WIDTH, 4095));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, -1024, 1'b1));
		// roi starting past every pixel seen
		plan.push_back(write_row(cbco_pkg::REG_ROI_LEFT, 2047));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b0));
		plan.push_back(write_row(cbco_pkg::REG_ROI_LEFT, 0));
		plan.push_back(write_row(cbco_pkg::REG_ROI_WIDTH, 0));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b0));
		plan.push_back(write_row(cbco_pkg::REG_ROI_WIDTH, 2048));
		plan.push_back(write_row(cbco_pkg::REG_ROI_HEIGHT, 0));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b0));
		plan.push_back(write_row(cbco_pkg::REG_ROI_TOP, 2047));
		plan.push_back(write_row(cbco_pkg::REG_ROI_HEIGHT, 1));
		plan.push_back(known_row(8'h80, 8'h80, 8'h80, 0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 21;
		out_idle_pct = 88;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
				cfg_valid <= 1'b0;
			end else begin
				typed_res.off = plan[i].off;
				typed_res.fnd = plan[i].fnd;
				send_pixel(plan[i].h, plan[i].s, plan[i].b, plan[i].fe,
					plan[i].typed, typed_res);
			end
		end

		// random frames in three idling phases, new register set every few frames
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					in_idle_pct = 21;
					out_idle_pct = 88;
				end
				1: begin
					in_idle_pct = 88;
					out_idle_pct = 21;
				end
				default: begin
					in_idle_pct = 0;
					out_idle_pct = 0;
				end
			endcase
			sent = 0;
			fr = 0;
			while (sent < 430) begin
				if (fr % 6 == 0) begin
					settle();
					choose_setting();
					cfg_valid <= 1'b0;
				end else if ($urandom_range(7) == 0) begin
					// hold the sender until the output side has emptied
					settle();
				end
				eff = line_width();
				if (eff <= 16)
					len = $urandom_range((3 * eff + 2 > 48) ? 48 : 3 * eff + 2, 1);
				else
					len = $urandom_range(40, 1);
				send_frame(len);
				sent += len;
				fr++;
			end
		end

		settle();
		if (err_cnt == 0)
			$display("[color_blob_centroid_offset] OK");
		else
			$display("[color_blob_centroid_offset] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cbco_pkg.sv
src/cbco_pixel.sv
src/cbco_div.sv
src/color_blob_centroid_offset.sv
tb/color_blob_centroid_offset_tb.sv
